// ===== hdl/assert_macros.svh =====
// Assertion helpers for the I2C byte engine RTL.
// Clocked on clk, disabled while rst_n is low; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising edge of clk, off during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ime_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// Used by ime_seq and i2c_master_byte_engine; no dependencies.
package ime_pkg;

    localparam int DELAY_W   = 16;
    localparam int TIMEOUT_W = 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [DELAY_W-1:0]   DELAY_RESET   = 16'd5;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 8'd250;

    // register select, paddr[2]
    localparam logic REG_DELAY   = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_READ     = 3'd4,
        CMD_WAIT_ACK = 3'd5
    } cmd_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_S1, PH_S2, PH_P1, PH_P2, PH_W1, PH_W2, PH_W3,
        PH_R1, PH_R2, PH_R3, PH_A1, PH_A2, PH_K1, PH_K2, PH_K3
    } phase_t;

    typedef struct packed {
        logic       sda_level;
        logic       send_ack;
        logic [7:0] write_byte;
        logic [2:0] command;
    } item_t;

    typedef struct packed {
        logic       ack_failed;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_release;
        logic       scl_release;
    } result_t;

endpackage

// ===== hdl/ime_seq.sv =====
// Bus sequencer state and per-tick next-state logic of the I2C byte engine.
// Depends on ime_pkg.
module ime_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step_en,
    input  ime_pkg::item_t                 item,
    input  logic [ime_pkg::DELAY_W-1:0]    delay_ticks,
    input  logic [ime_pkg::TIMEOUT_W-1:0]  ack_timeout,
    output ime_pkg::result_t               result
);
    import ime_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [3:0]           bit_reg, bit_next;
    logic [7:0]           shift_reg, shift_next;
    logic [7:0]           poll_reg, poll_next;
    logic                 ack_reg, ack_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic                 fail_reg, fail_next;
    logic [7:0]           rx_reg, rx_next;
    logic                 done;

    logic [DELAY_W-1:0]   dly_load;
    logic [3:0]           bit_inc;
    logic [8:0]           poll_inc;
    logic                 poll_over;
    logic                 expired;

    // zero delay behaves as one tick per phase
    assign dly_load  = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
    assign bit_inc   = bit_reg + 4'd1;
    assign poll_inc  = {1'b0, poll_reg} + 9'd1;
    assign poll_over = poll_inc > {1'b0, ack_timeout};
    assign expired   = (phase_reg != PH_IDLE) && (phase_reg != PH_K3)
                       && (delay_reg <= DELAY_W'(1));

    always_comb
    begin
        phase_next = phase_reg;
        if (phase_reg == PH_IDLE)
        begin
            case (item.command)
                CMD_START:    phase_next = PH_S1;
                CMD_STOP:     phase_next = PH_P1;
                CMD_WRITE:    phase_next = PH_W1;
                CMD_READ:     phase_next = PH_R1;
                CMD_WAIT_ACK: phase_next = PH_K1;
                default:      phase_next = PH_IDLE;
            endcase
        end
        else if (phase_reg == PH_K3)
        begin
            if (!item.sda_level)
                phase_next = PH_IDLE;
            else if (poll_over)
                phase_next = PH_P1;
        end
        else if (expired)
        begin
            case (phase_reg)
                PH_S1:   phase_next = PH_S2;
                PH_P1:   phase_next = PH_P2;
                PH_W1:   phase_next = PH_W2;
                PH_W2:   phase_next = PH_W3;
                PH_W3:   phase_next = bit_inc[3] ? PH_IDLE : PH_W1;
                PH_R1:   phase_next = PH_R2;
                PH_R2:   phase_next = PH_R3;
                PH_R3:   phase_next = bit_inc[3] ? PH_A1 : PH_R1;
                PH_A1:   phase_next = PH_A2;
                PH_K1:   phase_next = PH_K2;
                PH_K2:   phase_next = PH_K3;
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb
    begin
        delay_next = delay_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        poll_next  = poll_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        fail_next  = fail_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            case (item.command)
                CMD_START:
                begin
                    scl_next = 1'b1;  sda_next = 1'b1;  delay_next = dly_load;
                end
                CMD_STOP:
                begin
                    scl_next = 1'b0;  sda_next = 1'b0;  delay_next = dly_load;
                end
                CMD_WRITE:
                begin
                    shift_next = item.write_byte;
                    bit_next   = '0;
                    sda_next   = item.write_byte[7];
                    delay_next = dly_load;
                end
                CMD_READ:
                begin
                    shift_next = '0;
                    bit_next   = '0;
                    ack_next   = item.send_ack;
                    scl_next   = 1'b0;  sda_next = 1'b1;  delay_next = dly_load;
                end
                CMD_WAIT_ACK:
                begin
                    fail_next  = 1'b0;
                    poll_next  = '0;
                    sda_next   = 1'b1;
                    delay_next = dly_load;
                end
                default: ;
            endcase
        end
        else if (phase_reg == PH_K3)
        begin
            if (!item.sda_level)
            begin
                scl_next   = 1'b0;
                delay_next = '0;
                done       = 1'b1;
            end
            else if (poll_over)
            begin
                // timed out: flag it and run a stop
                fail_next  = 1'b1;
                scl_next   = 1'b0;  sda_next = 1'b0;  delay_next = dly_load;
            end
            else
                poll_next = poll_inc[7:0];
        end
        else if (!expired)
            delay_next = delay_reg - DELAY_W'(1);
        else
        begin
            delay_next = dly_load;
            case (phase_reg)
                PH_S1: begin scl_next = 1'b1; sda_next = 1'b0; end
                PH_S2:
                begin
                    scl_next = 1'b0;  delay_next = '0;  done = 1'b1;
                end
                PH_P1: begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_P2: begin delay_next = '0; done = 1'b1; end
                PH_W1: scl_next = 1'b1;
                PH_W2: scl_next = 1'b0;
                PH_W3:
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next   = bit_inc;
                    if (bit_inc[3])
                    begin
                        delay_next = '0;
                        done       = 1'b1;
                    end
                    else
                        sda_next = shift_reg[6];
                end
                PH_R1: begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_R2:
                begin
                    // sample at the end of SCL high
                    shift_next = {shift_reg[6:0], item.sda_level};
                    scl_next   = 1'b1;  sda_next = 1'b1;
                end
                PH_R3:
                begin
                    bit_next = bit_inc;
                    scl_next = 1'b0;
                    sda_next = bit_inc[3] ? !ack_reg : 1'b1;
                end
                PH_A1: scl_next = 1'b1;
                PH_A2:
                begin
                    scl_next   = 1'b0;
                    rx_next    = shift_reg;
                    delay_next = '0;
                    done       = 1'b1;
                end
                PH_K1: begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_K2:
                begin
                    poll_next  = '0;
                    delay_next = '0;
                end
                default:
                begin
                    delay_next = '0;
                    done       = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            delay_reg <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            poll_reg  <= '0;
            ack_reg   <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            fail_reg  <= 1'b0;
            rx_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            delay_reg <= delay_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            poll_reg  <= poll_next;
            ack_reg   <= ack_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            fail_reg  <= fail_next;
            rx_reg    <= rx_next;
        end
    end

    always_comb
    begin
        result.scl_release = scl_next;
        result.sda_release = sda_next;
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done;
        result.read_byte   = rx_next;
        result.ack_failed  = fail_next;
    end

endmodule

// ===== hdl/i2c_master_byte_engine.sv =====
// I2C master byte engine, top level: stream ports, APB registers, pipeline.
// Depends on ime_pkg, ime_seq and assert_macros.svh.
//
// Each transfer on the s_ side is one bus tick: a command (none, start, stop,
// write byte, read byte, wait ack) with its byte, the ACK choice and the
// sampled SDA level. Each tick gives exactly one transfer on the m_ side with
// the open-drain SCL/SDA releases, busy, a done pulse, the last read byte and
// the acknowledge-timeout flag, all as they stand after that tick.
// A tick enters an input register, is processed against the sequencer state
// once the result register is free or being drained, and lands in the result
// register that drives the m_ side. One tick per clock is sustained while
// m_tready is high; the sequencer state advances by one tick per cycle in
// which step_en is high, through a single pass of next-state logic.
// A stalled m_tready holds the result register and the input register takes
// one more tick before s_tready drops.
// Reset: delay_ticks 5, ack_timeout 250, sequencer idle, both lines released.
// Registers (APB, byte address): 0x0 delay_ticks, 0x4 ack_timeout; write them
// only while the sequencer is idle and the pipeline is empty.
module i2c_master_byte_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [2:0] command, [10:3] write_byte, [11] send_ack, [12] sda_level
    input  logic [15:0]                  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] scl_release, [1] sda_release, [2] busy_res, [3] done_res,
    // [11:4] read_byte, [12] ack_failed
    output logic [15:0]                  m_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ime_pkg::APB_AW-1:0]   paddr,
    input  logic [ime_pkg::APB_DW-1:0]   pwdata,
    output logic [ime_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import ime_pkg::*;

    `include "assert_macros.svh"

    logic [DELAY_W-1:0]   delay_ticks_reg;
    logic [TIMEOUT_W-1:0] ack_timeout_reg;
    item_t                in_item_reg;
    logic                 in_valid_reg;
    result_t              out_res_reg;
    logic                 out_valid_reg;
    result_t              step_res;
    logic                 step_en;
    logic                 s_xfer;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg <= DELAY_RESET;
            ack_timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_DELAY:   delay_ticks_reg <= pwdata[DELAY_W-1:0];
                REG_TIMEOUT: ack_timeout_reg <= pwdata[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_DELAY:   prdata = {{(APB_DW-DELAY_W){1'b0}}, delay_ticks_reg};
            REG_TIMEOUT: prdata = {{(APB_DW-TIMEOUT_W){1'b0}}, ack_timeout_reg};
            default:     prdata = '0;
        endcase
    end

    // a tick moves on when the result register is free or being drained
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_xfer)
            in_valid_reg <= 1'b1;
        else if (step_en)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
            in_item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
    end

    ime_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .item        (in_item_reg),
        .delay_ticks (delay_ticks_reg),
        .ack_timeout (ack_timeout_reg),
        .result      (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-$bits(result_t)){1'b0}}, out_res_reg};

    `ASSERT_CLK(a_done_not_busy, !(out_valid_reg && out_res_reg.done_res
        && out_res_reg.busy_res), "done pulse while still busy")
    `ASSERT_NEXT(a_in_hold, in_valid_reg && !step_en, in_valid_reg,
        "pending tick lost from input register")
    `ASSERT_CLK(a_no_overrun, !(in_valid_reg && !step_en && s_tready),
        "input register overrun")

endmodule

// ===== tb/i2c_master_byte_engine_tb.sv =====
// Self-checking testbench for the I2C master byte engine: a directed table, then
// random bus transactions under several handshake stall patterns.
// Depends on ime_pkg and i2c_master_byte_engine; needs no files.
module i2c_master_byte_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ime_pkg::*;

    // command codes with no meaning; the engine treats them as no command
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    localparam result_t RESET_RES = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam int      MAX_PRINT = 40;

    typedef struct packed {
        logic        is_cfg;
        logic        reg_sel;
        logic [15:0] cfg_val;
        item_t       it;
        logic        drain;
        logic        typed;
        result_t     want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    i2c_master_byte_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // sequencer copy, advanced once per accepted tick
    logic [15:0] cfg_delay = DELAY_RESET;
    logic [7:0]  cfg_timeout = TIMEOUT_RESET;
    phase_t      ph = PH_IDLE;
    logic [15:0] dly_q = '0;
    logic [3:0]  bits = '0;
    logic [7:0]  shreg = '0;
    logic [7:0]  polls = '0;
    logic        ackc = 1'b0;
    logic        scl_q = 1'b1;
    logic        sda_q = 1'b1;
    logic        fail_q = 1'b0;
    logic [7:0]  rxb = '0;
    logic        done_q = 1'b0;

    result_t     pending_ticks[$];
    int          n_errors = 0;
    int          n_ticks = 0;
    int          n_results = 0;
    int          n_cmds = 0;
    int          n_timeouts = 0;
    int          n_reads = 0;
    int          send_gap_pct = 0;
    int          rcv_stall_pct = 0;
    int          hold_left = 0;

    // random transaction generator state
    bit          bus_open = 1'b0;
    bit          ack_due = 1'b0;
    int          ack_at = 0;
    int          polls_seen = 0;

    function automatic void enter_ph(phase_t p, logic s, logic d);
        ph = p;
        scl_q = s;
        sda_q = d;
        dly_q = (cfg_delay != 0) ? cfg_delay : 16'd1;
    endfunction

    function automatic void finish_cmd();
        ph = PH_IDLE;
        dly_q = '0;
        done_q = 1'b1;
    endfunction

    function automatic void advance_ph();
        case (ph)
            PH_S1: enter_ph(PH_S2, 1'b1, 1'b0);
            PH_S2:
            begin
                scl_q = 1'b0;
                finish_cmd();
            end
            PH_P1: enter_ph(PH_P2, 1'b1, 1'b1);
            PH_P2: finish_cmd();
            PH_W1: enter_ph(PH_W2, 1'b1, sda_q);
            PH_W2: enter_ph(PH_W3, 1'b0, sda_q);
            PH_W3:
            begin
                shreg = shreg << 1;
                bits = bits + 4'd1;
                if (bits >= 4'd8)
                    finish_cmd();
                else
                    enter_ph(PH_W1, scl_q, shreg[7]);
            end
            PH_R1: enter_ph(PH_R2, 1'b1, 1'b1);
            PH_R2: enter_ph(PH_R3, 1'b1, 1'b1);
            PH_R3:
            begin
                bits = bits + 4'd1;
                if (bits >= 4'd8)
                    enter_ph(PH_A1, 1'b0, !ackc);
                else
                    enter_ph(PH_R1, 1'b0, 1'b1);
            end
            PH_A1: enter_ph(PH_A2, 1'b1, sda_q);
            PH_A2:
            begin
                scl_q = 1'b0;
                rxb = shreg;
                n_reads++;
                finish_cmd();
            end
            PH_K1: enter_ph(PH_K2, 1'b1, 1'b1);
            PH_K2:
            begin
                polls = '0;
                ph = PH_K3;
                dly_q = '0;
            end
            default: finish_cmd();
        endcase
    endfunction

    function automatic result_t engine_tick(item_t it);
        result_t r;
        int      nxt;
        done_q = 1'b0;
        if (ph == PH_IDLE)
        begin
            case (it.command)
                CMD_START: enter_ph(PH_S1, 1'b1, 1'b1);
                CMD_STOP:  enter_ph(PH_P1, 1'b0, 1'b0);
                CMD_WRITE:
                begin
                    shreg = it.write_byte;
                    bits = '0;
                    enter_ph(PH_W1, scl_q, it.write_byte[7]);
                end
                CMD_READ:
                begin
                    shreg = '0;
                    bits = '0;
                    ackc = it.send_ack;
                    enter_ph(PH_R1, 1'b0, 1'b1);
                end
                CMD_WAIT_ACK:
                begin
                    fail_q = 1'b0;
                    polls = '0;
                    enter_ph(PH_K1, scl_q, 1'b1);
                end
                default: ;
            endcase
        end
        else if (ph == PH_K3)
        begin
            if (!it.sda_level)
            begin
                scl_q = 1'b0;
                finish_cmd();
            end
            else
            begin
                nxt = int'(polls) + 1;
                if (nxt > int'(cfg_timeout))
                begin
                    fail_q = 1'b1;
                    n_timeouts++;
                    enter_ph(PH_P1, 1'b0, 1'b0);
                end
                else
                    polls = nxt[7:0];
            end
        end
        else if (dly_q > 16'd1)
            dly_q = dly_q - 16'd1;
        else
        begin
            // read data is taken at the end of the SCL-high phase
            if (ph == PH_R2)
                shreg = {shreg[6:0], it.sda_level};
            advance_ph();
        end
        r.scl_release = scl_q;
        r.sda_release = sda_q;
        r.busy_res    = (ph != PH_IDLE);
        r.done_res    = done_q;
        r.read_byte   = rxb;
        r.ack_failed  = fail_q;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (n_errors < MAX_PRINT)
            $display("mismatch at result %0d: %s got %0h want %0h", n_results, what, got, want);
        n_errors++;
    endtask

    task automatic send_tick(item_t it, bit typed, result_t want);
        result_t r;
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, it};
        do
            @(posedge clk);
        while (!s_tready);
        r = engine_tick(it);
        pending_ticks.push_back(typed ? want : r);
        n_ticks++;
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        wait (pending_ticks.size() == 0);
        @(posedge clk);
    endtask

    // empty ticks until the sequencer is back to idle
    task automatic drain_engine(logic sda);
        item_t it;
        it = '0;
        it.command = CMD_NONE;
        it.sda_level = sda;
        while (ph != PH_IDLE)
            send_tick(it, 1'b0, RESET_RES);
    endtask

    task automatic write_reg(logic sel, logic [15:0] val);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {16'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (sel == REG_DELAY)
            cfg_delay = val;
        else
            cfg_timeout = val[7:0];
        want = (sel == REG_DELAY) ? {16'h0, val} : {24'h0, val[7:0]};
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            report_mismatch("register readback", prdata[15:0], want[15:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic dir_row_t tick_row(logic [2:0] cmd, logic [7:0] wb, logic ack,
                                          logic sda, logic drain, logic typed);
        dir_row_t row;
        row = '0;
        row.it.command    = cmd;
        row.it.write_byte = wb;
        row.it.send_ack   = ack;
        row.it.sda_level  = sda;
        row.drain         = drain;
        row.typed         = typed;
        row.want          = RESET_RES;
        return row;
    endfunction

    function automatic dir_row_t cfg_row(logic sel, logic [15:0] val);
        dir_row_t row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_sel = sel;
        row.cfg_val = val;
        return row;
    endfunction

    function automatic item_t next_tick();
        item_t it;
        int    r;
        it.write_byte = 8'($urandom_range(255));
        it.send_ack   = 1'($urandom_range(1));
        it.sda_level  = 1'($urandom_range(1));
        it.command    = CMD_NONE;
        if (ph == PH_IDLE)
        begin
            r = $urandom_range(99);
            if (r < 10)
                it.command = 3'($urandom_range(7));
            else if (r < 18)
                it.command = CMD_NONE;
            else if (!bus_open)
            begin
                it.command = CMD_START;
                bus_open = 1'b1;
            end
            else if (ack_due)
            begin
                it.command = CMD_WAIT_ACK;
                ack_due = 1'b0;
                polls_seen = 0;
                // a quarter of the waits never see an acknowledge
                ack_at = ($urandom_range(99) < 75) ? $urandom_range(3) : 1000;
                if (ack_at == 1000)
                    bus_open = 1'b0;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 40)
                begin
                    it.command = CMD_WRITE;
                    ack_due = 1'b1;
                end
                else if (r < 70)
                    it.command = CMD_READ;
                else if (r < 80)
                    it.command = CMD_START;
                else
                begin
                    it.command = CMD_STOP;
                    bus_open = 1'b0;
                end
            end
        end
        else
        begin
            if (ph == PH_K3)
            begin
                it.sda_level = (polls_seen >= ack_at) ? 1'b0 : 1'b1;
                polls_seen++;
            end
            // commands while busy must be ignored
            if ($urandom_range(99) < 25)
                it.command = 3'($urandom_range(7));
        end
        return it;
    endfunction

    // result side: random stalls, plus a counted hold-off on request
    initial
    begin
        result_t got;
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = m_tdata[12:0];
                n_results++;
                if (pending_ticks.size() == 0)
                    report_mismatch("result with none expected", m_tdata, 16'h0);
                else
                begin
                    want = pending_ticks.pop_front();
                    if (got.scl_release !== want.scl_release)
                        report_mismatch("scl_release", 16'(got.scl_release),
                                        16'(want.scl_release));
                    if (got.sda_release !== want.sda_release)
                        report_mismatch("sda_release", 16'(got.sda_release),
                                        16'(want.sda_release));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", 16'(got.busy_res), 16'(want.busy_res));
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", 16'(got.done_res), 16'(want.done_res));
                    if (got.read_byte !== want.read_byte)
                        report_mismatch("read_byte", 16'(got.read_byte), 16'(want.read_byte));
                    if (got.ack_failed !== want.ack_failed)
                        report_mismatch("ack_failed", 16'(got.ack_failed),
                                        16'(want.ack_failed));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    initial
    begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        dir_row_t rows[$];
        item_t    it;
        int       gap_pct[4]  = '{0, 54, 0, 35};
        int       stall_pct[4] = '{0, 0, 54, 35};
        int       delays[4]   = '{1, 2, 3, 1};
        int       timeouts[4] = '{3, 12, 1, 255};
        int       target;

        rows.push_back(tick_row(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1));
        rows.push_back(tick_row(CMD_RSVD6, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1));
        rows.push_back(tick_row(CMD_RSVD7, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1));
        rows.push_back(tick_row(CMD_START, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
        rows.push_back(tick_row(CMD_WRITE, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b0));
        rows.push_back(tick_row(CMD_WAIT_ACK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
        rows.push_back(tick_row(CMD_WRITE, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0));
        // no acknowledge: times out after the reset limit of polls
        rows.push_back(tick_row(CMD_WAIT_ACK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
        rows.push_back(tick_row(CMD_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
        rows.push_back(tick_row(CMD_WRITE, 8'h5A, 1'b1, 1'b1, 1'b0, 1'b0));
        rows.push_back(tick_row(CMD_NONE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
        rows.push_back(tick_row(CMD_READ, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0));
        rows.push_back(tick_row(CMD_READ, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b0));
        rows.push_back(tick_row(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
        rows.push_back(cfg_row(REG_DELAY, 16'd0));
        rows.push_back(cfg_row(REG_TIMEOUT, 16'd0));
        rows.push_back(tick_row(CMD_START, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
        rows.push_back(tick_row(CMD_WAIT_ACK, 8'h80, 1'b0, 1'b1, 1'b1, 1'b0));
        rows.push_back(cfg_row(REG_TIMEOUT, 16'd255));
        rows.push_back(cfg_row(REG_DELAY, 16'd1));
        rows.push_back(tick_row(CMD_WAIT_ACK, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
        rows.push_back(tick_row(CMD_READ, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
        rows.push_back(cfg_row(REG_DELAY, 16'hFFFF));
        // widest delay checked by readback only; a short one for the stop
        rows.push_back(cfg_row(REG_DELAY, 16'd4));
        rows.push_back(tick_row(CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                idle_sender();
                write_reg(rows[i].reg_sel, rows[i].cfg_val);
            end
            else
            begin
                send_tick(rows[i].it, rows[i].typed, rows[i].want);
                if (rows[i].drain)
                    drain_engine(rows[i].it.sda_level);
            end
        end

        for (int p = 0; p < 4; p++)
        begin
            idle_sender();
            write_reg(REG_DELAY, 16'(delays[p]));
            write_reg(REG_TIMEOUT, 16'(timeouts[p]));
            send_gap_pct  = gap_pct[p];
            rcv_stall_pct = stall_pct[p];
            // long hold-off on the result side while ticks keep coming
            if (p == 2)
                hold_left = 80;
            target = n_ticks + 180;
            while (n_ticks < target)
            begin
                it = next_tick();
                if (ph == PH_IDLE && it.command >= CMD_START && it.command <= CMD_WAIT_ACK)
                    n_cmds++;
                send_tick(it, 1'b0, RESET_RES);
                if (p == 1 && n_ticks == target - 90)
                    idle_sender();
            end
            drain_engine(1'b0);
        end

        s_tvalid <= 1'b0;
        wait (pending_ticks.size() == 0);
        repeat (20) @(posedge clk);

        $display("ran %0d ticks with %0d commands under four stall patterns", n_ticks, n_cmds);
        $display("reads completed %0d, acknowledge timeouts %0d, results checked %0d",
                 n_reads, n_timeouts, n_results);
        if (n_errors == 0 && pending_ticks.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
